@@ rtl/stable_priority_queue_defines.svh @@
// assertion macros used by the rtl top level
`ifndef STABLE_PRIORITY_QUEUE_DEFINES_SVH
`define STABLE_PRIORITY_QUEUE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define SPQ_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle check");

// next-cycle implication, checked outside reset
`define SPQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle check");

`endif

@@ rtl/spq_pkg.sv @@
package spq_pkg;

    // width of the fill count field in a result
    localparam int FILL_BITS = 5;

    // command codes carried in s_tuser
    localparam logic OP_ENQUEUE = 1'b0;
    localparam logic OP_DEQUEUE = 1'b1;

    typedef enum logic [1:0] {
        STAT_DONE  = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2
    } spq_status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DEQ,
        ST_SCAN,
        ST_PUT,
        ST_RESULT
    } spq_state_t;

    // result strobe from the sequencer to the output register
    typedef struct packed {
        logic        valid;
        spq_status_t status;
    } spq_res_t;

endpackage

@@ rtl/stable_priority_queue.sv @@
// Bounded priority queue, highest priority first, equal priorities in arrival
// order. s_tuser selects enqueue or dequeue; every command gives exactly one
// result transfer with a status, the dequeued entry (zero otherwise) and the
// fill count after the command. Entries live in a single-port-write,
// registered-read memory addressed as a ring; one sequencer with one priority
// comparator does the work, one memory entry per cycle. A dequeue passes through
// ST_DEQ to ST_RESULT; a rejected enqueue or a dequeue on an empty queue goes
// straight to ST_RESULT. An enqueue visits in ST_SCAN each stored entry of lower
// priority, moving it back one place, and writes the new entry in ST_SCAN or in
// ST_PUT before ST_RESULT. The result sits in an output register, so the
// next command is processed while it waits; a command only stalls before its
// result if the previous result has not been taken yet.
`include "stable_priority_queue_defines.svh"

module stable_priority_queue import spq_pkg::*; #(
    parameter int QUEUE_DEPTH   = 16,
    parameter int VALUE_BITS    = 16,
    parameter int PRIORITY_BITS = 3
) (
    input  logic aclk,
    input  logic aresetn,
    // command transfer
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // item_value, item_priority
    input  logic [((VALUE_BITS+PRIORITY_BITS+7)/8)*8-1:0] s_tdata,
    // operation
    input  logic                  s_tuser,
    // result transfer
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // out_value, out_priority, fill_count
    output logic [((VALUE_BITS+PRIORITY_BITS+FILL_BITS+7)/8)*8-1:0] m_tdata,
    // status
    output logic [1:0]            m_tuser
);

    localparam int CW    = $clog2(QUEUE_DEPTH + 1);
    localparam int OUT_W = ((VALUE_BITS + PRIORITY_BITS + FILL_BITS + 7) / 8) * 8;

    spq_res_t                 res;
    logic [VALUE_BITS-1:0]    res_value;
    logic [PRIORITY_BITS-1:0] res_priority;
    logic [CW-1:0]            res_count;
    logic                     res_free;

    logic                     m_tvalid_reg, m_tvalid_next;
    logic [OUT_W-1:0]         m_tdata_reg, m_tdata_next;
    logic [1:0]               m_tuser_reg, m_tuser_next;

    spq_seq #(
        .QUEUE_DEPTH   (QUEUE_DEPTH),
        .VALUE_BITS    (VALUE_BITS),
        .PRIORITY_BITS (PRIORITY_BITS)
    ) u_seq (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd_valid    (s_tvalid),
        .cmd_ready    (s_tready),
        .cmd_op       (s_tuser),
        .cmd_value    (s_tdata[VALUE_BITS-1:0]),
        .cmd_priority (s_tdata[VALUE_BITS+PRIORITY_BITS-1:VALUE_BITS]),
        .res_free     (res_free),
        .res          (res),
        .res_value    (res_value),
        .res_priority (res_priority),
        .res_count    (res_count)
    );

    // output register is free when empty or drained this cycle
    assign res_free = !m_tvalid_reg || m_tready;

    always_comb begin
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        if (res.valid) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = OUT_W'({FILL_BITS'(res_count), res_priority, res_value});
            m_tuser_next  = res.status;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // the sequencer is not ready in the cycle after it accepts a command
    `SPQ_ASSERT_NEXT(a_busy_after_cmd, aclk, aresetn, s_tvalid && s_tready, !s_tready)
    // a result never overwrites one that has not been taken
    `SPQ_ASSERT_NOW(a_no_overwrite, aclk, aresetn, res.valid, !m_tvalid_reg || m_tready)
    // a rejected enqueue only happens on a full queue
    `SPQ_ASSERT_NOW(a_full_count, aclk, aresetn, res.valid && res.status == STAT_FULL, res_count == CW'(QUEUE_DEPTH))
    // an empty report only happens on an empty queue
    `SPQ_ASSERT_NOW(a_empty_count, aclk, aresetn, res.valid && res.status == STAT_EMPTY, res_count == '0)

endmodule

@@ rtl/spq_mem.sv @@
module spq_mem import spq_pkg::*; #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 19
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // single write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/spq_seq.sv @@
module spq_seq import spq_pkg::*; #(
    parameter int QUEUE_DEPTH   = 16,
    parameter int VALUE_BITS    = 16,
    parameter int PRIORITY_BITS = 3
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // command side
    input  logic                             cmd_valid,
    output logic                             cmd_ready,
    input  logic                             cmd_op,
    input  logic [VALUE_BITS-1:0]            cmd_value,
    input  logic [PRIORITY_BITS-1:0]         cmd_priority,
    // result side
    input  logic                             res_free,
    output spq_res_t                         res,
    output logic [VALUE_BITS-1:0]            res_value,
    output logic [PRIORITY_BITS-1:0]         res_priority,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0] res_count
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int EW = VALUE_BITS + PRIORITY_BITS;

    spq_state_t state_reg, state_next;
    logic [AW-1:0]            head_reg, head_next;
    logic [AW-1:0]            tail_reg, tail_next;
    logic [CW-1:0]            count_reg, count_next;
    logic [AW-1:0]            scan_reg, scan_next;
    logic [AW-1:0]            hole_reg, hole_next;
    logic [CW-1:0]            left_reg, left_next;
    logic [VALUE_BITS-1:0]    item_val_reg, item_val_next;
    logic [PRIORITY_BITS-1:0] item_pri_reg, item_pri_next;
    spq_status_t              status_reg, status_next;
    logic [VALUE_BITS-1:0]    oval_reg, oval_next;
    logic [PRIORITY_BITS-1:0] opri_reg, opri_next;

    logic                     mem_we;
    logic [AW-1:0]            mem_waddr;
    logic [EW-1:0]            mem_wdata;
    logic [AW-1:0]            mem_raddr;
    logic [EW-1:0]            mem_rdata;
    logic [VALUE_BITS-1:0]    rd_val;
    logic [PRIORITY_BITS-1:0] rd_pri;

    // circular index steps
    function automatic logic [AW-1:0] idx_inc(input logic [AW-1:0] x);
        return (x == AW'(QUEUE_DEPTH - 1)) ? '0 : x + 1'b1;
    endfunction

    function automatic logic [AW-1:0] idx_dec(input logic [AW-1:0] x);
        return (x == '0) ? AW'(QUEUE_DEPTH - 1) : x - 1'b1;
    endfunction

    spq_mem #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH (EW)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

    assign rd_val = mem_rdata[VALUE_BITS-1:0];
    assign rd_pri = mem_rdata[EW-1:VALUE_BITS];

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    // working registers of the current command
    always_ff @(posedge aclk) begin
        scan_reg     <= scan_next;
        hole_reg     <= hole_next;
        left_reg     <= left_next;
        item_val_reg <= item_val_next;
        item_pri_reg <= item_pri_next;
        status_reg   <= status_next;
        oval_reg     <= oval_next;
        opri_reg     <= opri_next;
    end

    // sequencer: dequeue reads the head; enqueue walks back from the tail, shifting lower priorities
    always_comb begin
        state_next    = state_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        count_next    = count_reg;
        scan_next     = scan_reg;
        hole_next     = hole_reg;
        left_next     = left_reg;
        item_val_next = item_val_reg;
        item_pri_next = item_pri_reg;
        status_next   = status_reg;
        oval_next     = oval_reg;
        opri_next     = opri_reg;
        mem_we        = 1'b0;
        mem_waddr     = hole_reg;
        mem_wdata     = {item_pri_reg, item_val_reg};
        mem_raddr     = scan_reg;
        cmd_ready     = 1'b0;
        res           = '{valid: 1'b0, status: status_reg};

        case (state_reg)
            ST_IDLE: begin
                cmd_ready = 1'b1;
                mem_raddr = (cmd_op == OP_DEQUEUE) ? head_reg : idx_dec(tail_reg);
                if (cmd_valid) begin
                    item_val_next = cmd_value;
                    item_pri_next = cmd_priority;
                    oval_next     = '0;
                    opri_next     = '0;
                    status_next   = STAT_DONE;
                    scan_next     = idx_dec(tail_reg);
                    hole_next     = tail_reg;
                    left_next     = count_reg;
                    if (cmd_op == OP_DEQUEUE) begin
                        if (count_reg == '0) begin
                            status_next = STAT_EMPTY;
                            state_next  = ST_RESULT;
                        end else begin
                            state_next = ST_DEQ;
                        end
                    end else begin
                        if (count_reg == CW'(QUEUE_DEPTH)) begin
                            status_next = STAT_FULL;
                            state_next  = ST_RESULT;
                        end else if (count_reg == '0) begin
                            state_next = ST_PUT;
                        end else begin
                            state_next = ST_SCAN;
                        end
                    end
                end
            end

            ST_DEQ: begin
                oval_next  = rd_val;
                opri_next  = rd_pri;
                head_next  = idx_inc(head_reg);
                count_next = count_reg - 1'b1;
                state_next = ST_RESULT;
            end

            ST_SCAN: begin
                mem_we = 1'b1;
                if (rd_pri < item_pri_reg) begin
                    // shift this entry one place back and look further ahead
                    mem_wdata = mem_rdata;
                    hole_next = scan_reg;
                    if (left_reg == CW'(1)) begin
                        state_next = ST_PUT;
                    end else begin
                        mem_raddr = idx_dec(scan_reg);
                        scan_next = idx_dec(scan_reg);
                        left_next = left_reg - 1'b1;
                    end
                end else begin
                    // slot found behind an entry of equal or higher priority
                    tail_next  = idx_inc(tail_reg);
                    count_next = count_reg + 1'b1;
                    state_next = ST_RESULT;
                end
            end

            ST_PUT: begin
                mem_we     = 1'b1;
                tail_next  = idx_inc(tail_reg);
                count_next = count_reg + 1'b1;
                state_next = ST_RESULT;
            end

            ST_RESULT: begin
                if (res_free) begin
                    res.valid  = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign res_value    = oval_reg;
    assign res_priority = opri_reg;
    assign res_count    = count_reg;

endmodule
